// File: design/ocf_pkg.sv
`timescale 1ns / 1ps
package ocf_pkg;

    // Fixed-point format of all positions
    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;

    // Register map
    localparam logic [2:0] REG_SPEED_PERCENT  = 3'd0;
    localparam logic [2:0] REG_MIN_STEP       = 3'd1;
    localparam logic [2:0] REG_YAW_DEG        = 3'd2;
    localparam logic [2:0] REG_PITCH_DEG      = 3'd3;
    localparam logic [2:0] REG_ORBIT_DISTANCE = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Register reset values
    localparam logic [9:0]  SPEED_RST = 10'd100;
    localparam logic [16:0] MINSTEP_RST = 17'd6554;
    localparam logic [8:0]  YAW_RST = 9'd0;
    localparam logic [7:0]  PITCH_RST = 8'd45;
    localparam logic [23:0] DIST_RST = 24'd655360;

    // ms * percent -> fraction of one, scaled by this
    localparam logic [16:0] STEP_DIV = 17'd100000;

    // Queue between front and back
    localparam int Q_DEPTH = 2;

    // Sine of a whole-degree angle, Q1.16 magnitude
    localparam int SIN_W = 17;
    localparam int FACTOR_W = 42;

    typedef struct packed {
        logic [9:0]  speed_percent;
        logic [16:0] min_step;
        logic [8:0]  yaw_deg;
        logic [7:0]  pitch_deg;
        logic [23:0] orbit_distance;
    } cfg_t;

    typedef struct packed {
        logic [FACTOR_W-1:0]       factor;
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] target_y;
        logic signed [COORD_W-1:0] target_z;
    } entry_t;

    typedef logic [90:0][SIN_W-1:0] sin_rom_t;

    // Series evaluation of sin(d degrees), d in 0..90, rounded to Q1.16
    function automatic logic [SIN_W-1:0] sin_quadrant(input int unsigned d);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        logic [63:0] res;
        x    = (64'(d) * 64'd3373259426 + 64'd90) / 64'd180;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + longint'(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        res = (64'(sum) + 64'd8192) >> 14;
        return res[SIN_W-1:0];
    endfunction

    function automatic sin_rom_t build_sin_rom();
        sin_rom_t rom;
        for (int i = 0; i <= 90; i++)
        begin
            rom[i] = sin_quadrant(i);
        end
        return rom;
    endfunction

    localparam sin_rom_t SIN_ROM = build_sin_rom();

    // Signed sine of an angle below 720 degrees
    function automatic logic signed [SIN_W:0] sin_deg(input logic [9:0] angle);
        logic [9:0]        a;
        logic              neg;
        logic [6:0]        d;
        logic [SIN_W-1:0]  v;
        a   = (angle >= 10'd360) ? angle - 10'd360 : angle;
        neg = (a >= 10'd180);
        if (neg)
        begin
            a = a - 10'd180;
        end
        if (a > 10'd90)
        begin
            a = 10'd180 - a;
        end
        d = a[6:0];
        v = SIN_ROM[d];
        return neg ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

endpackage

// File: design/ocf_front.sv
`timescale 1ns / 1ps
module ocf_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [127:0]        in_data,
    input  logic [9:0]          speed_percent,
    input  logic                q_full,
    output logic                q_push,
    output ocf_pkg::entry_t     q_entry
);

    logic [31:0] last_time_reg;
    logic [31:0] now_ms;
    logic [31:0] elapsed;

    assign now_ms   = in_data[31:0];
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // Elapsed time; no previous tick while last_time is zero
    assign elapsed = (last_time_reg == 32'd0) ? 32'd0 : now_ms - last_time_reg;

    always_comb
    begin
        q_entry.factor   = 42'(elapsed) * 42'(speed_percent);
        q_entry.target_x = in_data[63:32];
        q_entry.target_y = in_data[95:64];
        q_entry.target_z = in_data[127:96];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= '0;
        end
        else if (q_push)
        begin
            last_time_reg <= now_ms;
        end
    end

endmodule

// File: design/ocf_fifo.sv
`timescale 1ns / 1ps
module ocf_fifo
#(
    parameter int DEPTH = ocf_pkg::Q_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ocf_pkg::entry_t push_data,
    input  logic            pop,
    output ocf_pkg::entry_t pop_data,
    output logic            full,
    output logic            empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ocf_pkg::entry_t mem [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: design/ocf_back.sv
`timescale 1ns / 1ps
module ocf_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  ocf_pkg::cfg_t   cfg,
    input  logic            q_empty,
    input  ocf_pkg::entry_t q_data,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [191:0]    out_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL_LO = 3'd1;
    localparam logic [2:0] ST_MUL_HI = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_UPD    = 3'd4;
    localparam logic [2:0] ST_E_MUL  = 3'd5;
    localparam logic [2:0] ST_E_ACC  = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    localparam int DIV_W      = 80;
    localparam int DIG_W      = 8;
    localparam int DIV_DIGITS = DIV_W / DIG_W;
    localparam int X_W        = 25;
    localparam int RCP_W      = 26;
    localparam int RCP_PROD_W = X_W + RCP_W;
    localparam int RCP_SH     = 42;
    // ceil(2^42 / 100000): exact quotient for any partial dividend below 100000 * 2^8
    localparam logic [RCP_W-1:0] RCP_M = 26'd43980466;
    localparam int HALF_W     = ocf_pkg::FACTOR_W / 2;
    localparam int PROD_W     = 44;

    logic [2:0]         state_reg;
    ocf_pkg::entry_t    ent_reg;
    logic [1:0]         axis_reg;
    logic [1:0]         eidx_reg;
    logic [4:0]         cnt_reg;
    logic signed [31:0] look_reg [0:2];
    logic [32:0]        mag_reg;
    logic               neg_reg;
    logic [DIV_W-1:0]   acc_reg;
    logic [16:0]        rem_reg;
    logic               div_ph_reg;
    logic [RCP_PROD_W-1:0] rcp_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [25:0] dxy_reg;
    logic signed [31:0] fx_reg;
    logic signed [31:0] fy_reg;
    logic               out_valid_reg;
    logic [191:0]       out_data_reg;

    logic signed [31:0] cur;
    logic signed [31:0] tgt;
    logic signed [32:0] diff;
    logic [X_W-1:0]     x_div;
    logic [DIG_W-1:0]   q_dig;
    logic [DIV_W-1:0]   div_next;
    logic [16:0]        rem_next;
    logic               q_small;
    logic               mag_le_mn;
    logic signed [31:0] new_look;
    logic [9:0]         angle;
    logic signed [ocf_pkg::SIN_W:0] sine;
    logic signed [25:0] mul_a;
    logic signed [PROD_W-1:0] prod;
    logic signed [27:0] sh;
    logic signed [31:0] sh32;
    logic               out_load;

    assign cur = look_reg[axis_reg];

    always_comb
    begin
        case (axis_reg)
            2'd0:    tgt = ent_reg.target_x;
            2'd1:    tgt = ent_reg.target_y;
            default: tgt = ent_reg.target_z;
        endcase
    end

    assign diff = 33'(cur) - 33'(tgt);

    // Long division by the constant, one byte digit at a time:
    // reciprocal multiply first, then the quotient digit and remainder
    assign x_div    = {rem_reg, acc_reg[DIV_W-1 -: DIG_W]};
    assign q_dig    = rcp_reg[RCP_SH +: DIG_W];
    assign rem_next = 17'(x_div - X_W'(q_dig) * X_W'(ocf_pkg::STEP_DIV));
    assign div_next = {acc_reg[DIV_W-DIG_W-1:0], q_dig};

    // Axis update: proportional step, raised to the minimum step but not past target
    assign q_small   = (acc_reg[DIV_W-1:17] == '0) && (acc_reg[16:0] < cfg.min_step);
    assign mag_le_mn = (mag_reg <= 33'(cfg.min_step));

    always_comb
    begin
        if (q_small)
        begin
            if (mag_le_mn)
            begin
                new_look = tgt;
            end
            else
            begin
                new_look = neg_reg ? cur + 32'(cfg.min_step) : cur - 32'(cfg.min_step);
            end
        end
        else
        begin
            new_look = neg_reg ? cur + acc_reg[31:0] : cur - acc_reg[31:0];
        end
    end

    // Eye point: shared signed multiplier with the sine table
    always_comb
    begin
        case (eidx_reg)
            2'd0:    angle = 10'(cfg.pitch_deg);
            2'd1:    angle = 10'(cfg.yaw_deg);
            2'd2:    angle = 10'(cfg.yaw_deg) + 10'd90;
            default: angle = 10'(cfg.pitch_deg) + 10'd90;
        endcase
    end

    assign sine  = ocf_pkg::sin_deg(angle);
    assign mul_a = (eidx_reg == 2'd1 || eidx_reg == 2'd2) ? dxy_reg
                                                           : $signed({2'b00, cfg.orbit_distance});
    assign prod  = PROD_W'(mul_a) * PROD_W'(sine);
    assign sh    = 28'(prod_reg >>> ocf_pkg::FRAC_BITS);
    assign sh32  = 32'(sh);

    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Payload registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                ent_reg <= q_data;
            end
            ST_MUL_LO:
            begin
                mag_reg <= diff[32] ? 33'(-diff) : 33'(diff);
                neg_reg <= diff[32];
            end
            ST_DIV:
            begin
                if (!div_ph_reg)
                begin
                    rcp_reg <= RCP_PROD_W'(x_div) * RCP_PROD_W'(RCP_M);
                end
            end
            ST_E_MUL:
            begin
                prod_reg <= prod;
            end
            ST_E_ACC:
            begin
                case (eidx_reg)
                    2'd0:    dxy_reg <= sh[25:0];
                    2'd1:    fx_reg  <= look_reg[0] + sh32;
                    2'd2:    fy_reg  <= look_reg[1] - sh32;
                    default: fx_reg  <= fx_reg;
                endcase
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer, look-at state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= '0;
            eidx_reg      <= '0;
            cnt_reg       <= '0;
            acc_reg       <= '0;
            rem_reg       <= '0;
            div_ph_reg    <= 1'b0;
            look_reg[0]   <= '0;
            look_reg[1]   <= '0;
            look_reg[2]   <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    axis_reg <= '0;
                    eidx_reg <= '0;
                    if (!q_empty)
                    begin
                        state_reg <= ST_MUL_LO;
                    end
                end
                ST_MUL_LO:
                begin
                    acc_reg <= DIV_W'((diff[32] ? 33'(-diff) : 33'(diff))
                                      * 33'(ent_reg.factor[HALF_W-1:0]));
                    state_reg <= ST_MUL_HI;
                end
                ST_MUL_HI:
                begin
                    acc_reg <= acc_reg
                             + (DIV_W'(mag_reg * 33'(ent_reg.factor[ocf_pkg::FACTOR_W-1:HALF_W]))
                                << HALF_W);
                    rem_reg    <= '0;
                    cnt_reg    <= '0;
                    div_ph_reg <= 1'b0;
                    state_reg  <= ST_DIV;
                end
                ST_DIV:
                begin
                    div_ph_reg <= !div_ph_reg;
                    if (div_ph_reg)
                    begin
                        acc_reg <= div_next;
                        rem_reg <= rem_next;
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg == 5'(DIV_DIGITS - 1))
                        begin
                            state_reg <= ST_UPD;
                        end
                    end
                end
                ST_UPD:
                begin
                    look_reg[axis_reg] <= new_look;
                    if (axis_reg == 2'd2)
                    begin
                        state_reg <= ST_E_MUL;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 1'b1;
                        state_reg <= ST_MUL_LO;
                    end
                end
                ST_E_MUL:
                begin
                    state_reg <= ST_E_ACC;
                end
                ST_E_ACC:
                begin
                    if (eidx_reg == 2'd3)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        eidx_reg  <= eidx_reg + 1'b1;
                        state_reg <= ST_E_MUL;
                    end
                end
                ST_OUT:
                begin
                    // Wait for the previous result to leave
                    if (out_load)
                    begin
                        out_data_reg  <= {look_reg[2] + sh32, fy_reg, fx_reg,
                                          look_reg[2], look_reg[1], look_reg[0]};
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: design/orbit_camera_follow_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Beat contents
// s_axis    in         now_ms, target_x, target_y, target_z (one update tick)
// m_axis    out        at_x, at_y, at_z, from_x, from_y, from_z
// cfg       in         write of register cfg_index with cfg_data, no read-back
//
// The back end takes a tick from the queue, then per axis runs a low and a high multiply,
// a divide (one 8-bit quotient digit at a time by reciprocal multiplication against
// the constant 100000) and an update, then the eye point on one shared multiplier,
// and last loads the result.
// The front takes a tick each cycle while the queue has room. Reset clears the
// look-at point, the last timestamp and the registers to their defaults.
// A stalled result holds the back end in its last state; the queue keeps filling.
module orbit_camera_follow_unit
#(
    parameter int Q_DEPTH = ocf_pkg::Q_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // now_ms, target_x, target_y, target_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [191:0] m_axis_tdata,   // at_x, at_y, at_z, from_x, from_y, from_z
    input  logic         cfg_we,
    input  logic [ocf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ocf_pkg::CFG_DATA_W-1:0] cfg_data
);

    ocf_pkg::cfg_t   cfg_reg;
    ocf_pkg::entry_t push_entry;
    ocf_pkg::entry_t pop_entry;
    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed_percent  <= ocf_pkg::SPEED_RST;
            cfg_reg.min_step       <= ocf_pkg::MINSTEP_RST;
            cfg_reg.yaw_deg        <= ocf_pkg::YAW_RST;
            cfg_reg.pitch_deg      <= ocf_pkg::PITCH_RST;
            cfg_reg.orbit_distance <= ocf_pkg::DIST_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ocf_pkg::REG_SPEED_PERCENT:  cfg_reg.speed_percent  <= cfg_data[9:0];
                ocf_pkg::REG_MIN_STEP:       cfg_reg.min_step       <= cfg_data[16:0];
                ocf_pkg::REG_YAW_DEG:        cfg_reg.yaw_deg        <= cfg_data[8:0];
                ocf_pkg::REG_PITCH_DEG:      cfg_reg.pitch_deg      <= cfg_data[7:0];
                ocf_pkg::REG_ORBIT_DISTANCE: cfg_reg.orbit_distance <= cfg_data[23:0];
                default:
                begin
                end
            endcase
        end
    end

    ocf_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_data       (s_axis_tdata),
        .speed_percent (cfg_reg.speed_percent),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (push_entry)
    );

    ocf_fifo #(.DEPTH(Q_DEPTH)) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_entry),
        .pop       (q_pop),
        .pop_data  (pop_entry),
        .full      (q_full),
        .empty     (q_empty)
    );

    ocf_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_data    (pop_entry),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule
